/* src/ldf_pkg.sv */
package ldf_pkg;

  // Input kind codes.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Result kind codes.
  localparam logic RES_PAYLOAD    = 1'b0;
  localparam logic RES_FORMAT_ERR = 1'b1;

  // Header is four bytes, most significant first.
  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned HDR_CNT_W = $clog2(HDR_BYTES);
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_BYTES - 1);

  localparam int unsigned LEN_W = 32;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 32'd4194304;

  // One accepted input word.
  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } item_t;

  // One result word.
  typedef struct packed {
    logic             result_kind;
    logic [7:0]       payload_byte;
    logic             first_of_packet;
    logic             last_of_packet;
    logic [LEN_W-1:0] packet_length;
  } result_t;

endpackage

/* src/ldf_in_reg.sv */
module ldf_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic           s_tuser,   // kind
  input  logic [7:0]     s_tdata,   // in_byte
  input  logic           take,
  output logic           item_valid,
  output ldf_pkg::item_t item
);

  logic accept;

  // The stage takes a new word when empty or when its word moves on.
  assign s_tready = !item_valid || take;
  assign accept   = s_tvalid && s_tready;

  // Valid flag of the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // Payload of the input stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      item.kind    <= s_tuser;
      item.in_byte <= s_tdata;
    end
  end

endmodule

/* src/ldf_parser.sv */
module ldf_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [ldf_pkg::LEN_W-1:0] cfg_wdata,
  input  logic                     item_valid,
  input  ldf_pkg::item_t           item,
  input  logic                     buf_ready,
  output logic                     take,
  output logic                     res_valid,
  output ldf_pkg::result_t         res
);

  logic [ldf_pkg::LEN_W-1:0]     max_length;
  logic [ldf_pkg::HDR_CNT_W-1:0] header_bytes_seen, header_bytes_seen_next;
  logic [23:0]                   length_accumulator, length_accumulator_next;
  logic [ldf_pkg::LEN_W-1:0]     bytes_remaining, bytes_remaining_next;
  logic [ldf_pkg::LEN_W-1:0]     current_length, current_length_next;
  logic                          error_latched, error_latched_next;
  logic [ldf_pkg::LEN_W-1:0]     header_len;
  logic                          produce;

  assign take       = item_valid && buf_ready;
  assign res_valid  = take && produce;
  assign header_len = {length_accumulator, item.in_byte};

  // Limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= ldf_pkg::MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      max_length <= cfg_wdata;
    end
  end

  // Parse one word against the current state.
  always_comb begin
    header_bytes_seen_next  = header_bytes_seen;
    length_accumulator_next = length_accumulator;
    bytes_remaining_next    = bytes_remaining;
    current_length_next     = current_length;
    error_latched_next      = error_latched;
    produce                 = 1'b0;
    res                     = '0;
    if (item.kind == ldf_pkg::KIND_FLUSH) begin
      header_bytes_seen_next  = '0;
      length_accumulator_next = '0;
      bytes_remaining_next    = '0;
      current_length_next     = '0;
      error_latched_next      = 1'b0;
    end else if (!error_latched) begin
      if (bytes_remaining != '0) begin
        // Payload byte of the packet in flight.
        produce                 = 1'b1;
        res.result_kind         = ldf_pkg::RES_PAYLOAD;
        res.payload_byte        = item.in_byte;
        res.first_of_packet     = (bytes_remaining == current_length);
        res.last_of_packet      = (bytes_remaining == ldf_pkg::LEN_W'(1));
        res.packet_length       = current_length;
        bytes_remaining_next    = bytes_remaining - ldf_pkg::LEN_W'(1);
      end else if (header_bytes_seen != ldf_pkg::HDR_LAST) begin
        // Gather another header byte.
        length_accumulator_next = header_len[23:0];
        header_bytes_seen_next  = header_bytes_seen + ldf_pkg::HDR_CNT_W'(1);
      end else begin
        // Header complete: start a packet, skip an empty one, or flag oversize.
        header_bytes_seen_next  = '0;
        length_accumulator_next = '0;
        if (header_len > max_length) begin
          produce             = 1'b1;
          res.result_kind     = ldf_pkg::RES_FORMAT_ERR;
          res.packet_length   = header_len;
          error_latched_next  = 1'b1;
        end else if (header_len != '0) begin
          bytes_remaining_next = header_len;
          current_length_next  = header_len;
        end
      end
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes_seen  <= '0;
      length_accumulator <= '0;
      bytes_remaining    <= '0;
      current_length     <= '0;
      error_latched      <= 1'b0;
    end else if (take) begin
      header_bytes_seen  <= header_bytes_seen_next;
      length_accumulator <= length_accumulator_next;
      bytes_remaining    <= bytes_remaining_next;
      current_length     <= current_length_next;
      error_latched      <= error_latched_next;
    end
  end

  // A flush leaves the parser idle and clear of error.
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    take && item.kind == ldf_pkg::KIND_FLUSH |=> !error_latched && bytes_remaining == '0
      && header_bytes_seen == '0)
    else $error("flush did not clear parser state");

  // A format error is only reported once until the next flush.
  a_single_error: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.result_kind == ldf_pkg::RES_FORMAT_ERR |=> error_latched)
    else $error("format error not latched");

  // Payload never flows while an error is latched.
  a_no_payload_in_error: assert property (@(posedge clk) disable iff (rst)
    error_latched |-> !res_valid)
    else $error("result given while error latched");

  // The packet in flight never exceeds its own length.
  a_remaining_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_remaining <= current_length)
    else $error("remaining count above packet length");

endmodule

/* src/ldf_out_buf.sv */
module ldf_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ldf_pkg::result_t push_data,
  output logic             buf_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output ldf_pkg::result_t head
);

  logic [1:0]       count;
  ldf_pkg::result_t slot1;
  logic             pop;

  assign m_tvalid  = (count != 2'd0);
  assign buf_ready = (count != 2'd2);
  assign pop       = m_tvalid && m_tready;

  // Occupancy of the two-word buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Head word and skid word.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        head <= slot1;
      end else if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

  // Never written while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != 2'd2)
    else $error("result buffer overflow");

  // Occupancy stays within two words.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

endmodule

/* src/length_prefixed_deframer_unit.sv */
// Path: a word accepted into the input register passes the combinational parser and is
// registered in the result buffer, whose head word drives m_*.
// Throughput: one word per cycle unless the result buffer is full, set by the
// combinational parser between the input register and the two-word result buffer.
// Reset: rst is synchronous and active high; it clears the parser and both buffers,
// and sets max_length to 4194304.
module length_prefixed_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,  // max_length
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tuser,    // kind
  input  logic [7:0]  s_tdata,    // in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,    // result_kind, first_of_packet
  output logic [39:0] m_tdata,    // payload_byte, packet_length
  output logic        m_tlast     // last_of_packet
);

  logic             item_valid;
  ldf_pkg::item_t   item;
  logic             take;
  logic             buf_ready;
  logic             res_valid;
  ldf_pkg::result_t res;
  ldf_pkg::result_t head;

  ldf_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tuser    (s_tuser),
    .s_tdata    (s_tdata),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  ldf_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .buf_ready  (buf_ready),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  ldf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .buf_ready (buf_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .head      (head)
  );

  // Pack the result word onto the stream ports.
  assign m_tuser = {head.first_of_packet, head.result_kind};
  assign m_tdata = {head.packet_length, head.payload_byte};
  assign m_tlast = head.last_of_packet;

endmodule
